/* rtl/core/spq_pkg.sv */
package spq_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_POP_HEAD = 2'd1,
        OP_POP_TAIL = 2'd2,
        OP_REMOVE   = 2'd3
    } t_op;

    // What every cell of the row does in the current cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_UP,
        CELL_DROP_TAIL,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic signed [DATA_W-1:0]   value;
    } t_cell_cmd;

    typedef struct packed {
        t_op                        op;
        logic signed [DATA_W-1:0]   value;
    } t_in_item;

    typedef struct packed {
        logic                       ok;
        logic signed [DATA_W-1:0]   item;
        logic signed [DATA_W-1:0]   head_value;
        logic [COUNT_W-1:0]         entry_count;
        logic                       is_empty;
    } t_out_item;

endpackage

/* rtl/core/spq_cell.sv */
module spq_cell
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_cmd                 i_cmd,
    input  logic signed [DATA_W-1:0]  i_prev_entry,
    input  logic                      i_prev_valid,
    input  logic                      i_prev_ge,
    input  logic signed [DATA_W-1:0]  i_next_entry,
    input  logic                      i_next_valid,
    output logic signed [DATA_W-1:0]  o_entry,
    output logic                      o_valid,
    output logic                      o_ge,
    output logic signed [DATA_W-1:0]  o_next_entry,
    output logic                      o_next_valid
);

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;
    logic                     r_valid;
    logic                     n_valid;

    assign o_entry      = r_entry;
    assign o_valid      = r_valid;
    assign o_ge         = r_valid && (r_entry >= i_cmd.value);
    assign o_next_entry = n_entry;
    assign o_next_valid = n_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        unique case (i_cmd.op)
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            CELL_INSERT: begin
                // A cell holding a smaller value (or nothing) either takes the
                // new value, if it sits right after the last larger-or-equal
                // entry, or takes its upstream neighbor's entry.
                if (!o_ge) begin
                    if (i_prev_ge) begin
                        n_entry = i_cmd.value;
                        n_valid = 1'b1;
                    end else begin
                        n_entry = i_prev_entry;
                        n_valid = i_prev_valid;
                    end
                end
            end
            CELL_SHIFT_UP: begin
                n_entry = i_next_entry;
                n_valid = i_next_valid;
            end
            CELL_DROP_TAIL: begin
                n_valid = r_valid & i_next_valid;
            end
            CELL_REMOVE: begin
                // The row is sorted, so every cell at or after the first match
                // holds a value no larger than the key.
                if (r_valid && (r_entry <= i_cmd.value)) begin
                    n_entry = i_next_entry;
                    n_valid = i_next_valid;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

/* rtl/core/sorted_priority_queue_top.sv */
// Bounded priority queue built as a row of CAPACITY cells that hold the
// entries in descending order, largest at the head; every operation (insert,
// pop head, pop tail, remove by key) is done by all cells at once, each cell
// looking only at its two neighbors, so one item is accepted per cycle while
// o_in_stall is low; its result appears in the output register on the next
// cycle. The output register is the only buffer: input stall follows output
// stall only while a result is waiting. Entries need no clearing after reset.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] w_entry    [CAPACITY];
    logic signed [DATA_W-1:0] w_n_entry  [CAPACITY];
    logic signed [DATA_W-1:0] w_pe_in    [CAPACITY];
    logic signed [DATA_W-1:0] w_ne_in    [CAPACITY];
    logic [CAPACITY-1:0]      w_valid;
    logic [CAPACITY-1:0]      w_n_valid;
    logic [CAPACITY-1:0]      w_ge;
    logic [CAPACITY-1:0]      w_match;
    logic [CAPACITY-1:0]      w_pv_in;
    logic [CAPACITY-1:0]      w_pg_in;
    logic [CAPACITY-1:0]      w_nv_in;
    logic [CAPACITY-1:0]      w_tail;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    t_out_item                r_out_item;
    t_out_item                n_out_item;
    t_cell_cmd                w_cmd;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_found;
    logic signed [DATA_W-1:0] w_tail_item;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_found = |w_match;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            // The virtual cell ahead of the head is larger than any value.
            assign w_pe_in[gi] = '0;
            assign w_pv_in[gi] = 1'b1;
            assign w_pg_in[gi] = 1'b1;
        end else begin : g_mid
            assign w_pe_in[gi] = w_entry[gi-1];
            assign w_pv_in[gi] = w_valid[gi-1];
            assign w_pg_in[gi] = w_ge[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_ne_in[gi] = '0;
            assign w_nv_in[gi] = 1'b0;
        end else begin : g_body
            assign w_ne_in[gi] = w_entry[gi+1];
            assign w_nv_in[gi] = w_valid[gi+1];
        end
        assign w_tail[gi] = w_valid[gi] & ~w_nv_in[gi];
        // The key match is taken straight from the input item, so the command
        // that depends on it never feeds back into it.
        assign w_match[gi] = w_valid[gi] & (w_entry[gi] == i_in_item.value);

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev_entry (w_pe_in[gi]),
            .i_prev_valid (w_pv_in[gi]),
            .i_prev_ge    (w_pg_in[gi]),
            .i_next_entry (w_ne_in[gi]),
            .i_next_valid (w_nv_in[gi]),
            .o_entry      (w_entry[gi]),
            .o_valid      (w_valid[gi]),
            .o_ge         (w_ge[gi]),
            .o_next_entry (w_n_entry[gi]),
            .o_next_valid (w_n_valid[gi])
        );
    end

    // At most one tail flag is set, so the tail entry is an OR of masked entries.
    always_comb begin
        w_tail_item = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_tail_item = w_tail_item | (w_tail[i] ? w_entry[i] : '0);
        end
    end

    always_comb begin
        w_cmd.value = i_in_item.value;
        w_cmd.op    = CELL_HOLD;
        if (w_accept) begin
            unique case (i_in_item.op)
                OP_INSERT:   w_cmd.op = w_full  ? CELL_HOLD : CELL_INSERT;
                OP_POP_HEAD: w_cmd.op = w_empty ? CELL_HOLD : CELL_SHIFT_UP;
                OP_POP_TAIL: w_cmd.op = w_empty ? CELL_HOLD : CELL_DROP_TAIL;
                OP_REMOVE:   w_cmd.op = w_found ? CELL_REMOVE : CELL_HOLD;
                default:     w_cmd.op = CELL_HOLD;
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        n_out_item.ok   = 1'b0;
        n_out_item.item = '0;
        unique case (w_cmd.op)
            CELL_HOLD: begin
                n_count = r_count;
            end
            CELL_INSERT: begin
                n_count       = r_count + CNT_W'(1);
                n_out_item.ok = 1'b1;
            end
            CELL_SHIFT_UP: begin
                n_count         = r_count - CNT_W'(1);
                n_out_item.ok   = 1'b1;
                n_out_item.item = w_entry[0];
            end
            CELL_DROP_TAIL: begin
                n_count         = r_count - CNT_W'(1);
                n_out_item.ok   = 1'b1;
                n_out_item.item = w_tail_item;
            end
            CELL_REMOVE: begin
                n_count         = r_count - CNT_W'(1);
                n_out_item.ok   = 1'b1;
                n_out_item.item = w_cmd.value;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        w_count_ext            = {{COUNT_W{1'b0}}, n_count};
        n_out_item.head_value  = w_n_valid[0] ? w_n_entry[0] : '0;
        n_out_item.entry_count = w_count_ext[COUNT_W-1:0];
        n_out_item.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    // The count never runs past the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // The count always equals the number of occupied cells.
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("entry count disagrees with occupied cells");

    // Occupied cells form an unbroken run starting at the head.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + CAPACITY'(1))) == '0)
        else $error("gap in occupied cells");

    // Head entry is never smaller than its successor.
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> (w_entry[0] >= w_entry[1]))
        else $error("head entry out of order");

    // An accepted insert into a queue with room grows it by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.op == OP_INSERT && !w_full)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not add an entry");

endmodule
